// ----- src/kars_pkg.sv -----
// Keypad auto-repeat scanner: shared widths, types and the per-key decision struct.
// No dependencies; kars_key_eval and the top level use scoped names, the bench files import it.
package kars_pkg;

    localparam int NUM_KEYS  = 11;
    localparam int KEY_W     = 12;
    localparam int TICK_W    = 8;
    localparam int DELAY_W   = 7;
    localparam int ADDR_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int KEY_IDX_W = $clog2(KEY_W);

    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [KEY_IDX_W-1:0] t_key_idx;
    typedef logic [KEY_W-1:0]     t_keys;
    typedef logic [TICK_W-1:0]    t_tick;
    typedef logic [DELAY_W-1:0]   t_delay;

    // Input opcodes
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // Configuration register indexes
    localparam logic CFG_INITIAL_DELAY = 1'b0;
    localparam logic CFG_NEXT_DELAY    = 1'b1;

    // Decision for one key of the poll walk
    typedef struct packed {
        logic stop;      // end the walk at this key
        logic report;    // report this key as pressed
        logic wr;        // write a new deadline
        logic use_init;  // new deadline uses the initial delay
        logic set_held;
        logic clr_held;
    } t_key_dec;

endpackage

// ----- src/kars_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kars_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 11,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/kars_key_eval.sv -----
// Decision logic for one key of the poll walk: report, deadline write, held update.
// Depends on kars_pkg.
module kars_key_eval (
    input  logic              i_press,
    input  logic              i_repress,
    input  logic              i_release,
    input  logic              i_held,
    input  logic              i_due,
    output kars_pkg::t_key_dec o_dec
);

    always_comb begin
        o_dec = '0;
        if (!i_press) begin
            // not pressed: drop from held and go on
            o_dec.clr_held = 1'b1;
        end else if (i_repress) begin
            o_dec.stop     = 1'b1;
            o_dec.report   = 1'b1;
            o_dec.wr       = 1'b1;
            o_dec.use_init = 1'b1;
            o_dec.set_held = 1'b1;
        end else if (i_held) begin
            o_dec.clr_held = i_release;
            if (i_due) begin
                o_dec.stop   = 1'b1;
                o_dec.report = !i_release;
                o_dec.wr     = !i_release;
            end
        end else begin
            o_dec.stop     = 1'b1;
            o_dec.report   = !i_release;
            o_dec.wr       = !i_release;
            o_dec.use_init = 1'b1;
            o_dec.set_held = !i_release;
        end
    end

endmodule

// ----- src/keypad_autorepeat_scanner.sv -----
// Keypad auto-repeat scanner top level: latches, walk sequencer, output register.
// Depends on kars_pkg, kars_ram and kars_key_eval.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes scan items (opcode 0, keys_now)
//   and poll items (opcode 1, tick_now). A scan item updates the press, re-press
//   and release latches in the cycle it is accepted and gives no result.
//   A poll item starts a walk over keys 1..11, one key per cycle. Key deadlines
//   live in an 11-entry RAM with registered read data; the read for the next
//   key is issued while the current key is judged. The walk stops at the first
//   key latched as pressed, unless that key is held and not yet due.
//   A poll holds o_in_stall until its walk ends and its result is placed, and
//   its one result (pressed_keys, zero or one key bit) is shown on
//   o_out_valid / o_pressed_keys in the cycle after the walk ends when the
//   output register is free then.
//   The output register lets a scan be taken while a result waits; if the
//   receiver stalls when a walk ends, hold the result in the walker and keep
//   stalling the input until the output register frees up.
//   Reset (synchronous, active low) clears the latches, held keys and the
//   sequencer, and loads delays 15 and 3. Deadlines need no clearing: a key's
//   deadline is only used once the key is held, which requires a write first.
//   Configuration writes (i_cfg_we) take effect at once; write only when idle.
module keypad_autorepeat_scanner (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_opcode,
    input  logic [kars_pkg::KEY_W-1:0] i_keys_now,
    input  logic [kars_pkg::TICK_W-1:0] i_tick_now,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [kars_pkg::KEY_W-1:0] o_pressed_keys,
    // configuration
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [kars_pkg::DELAY_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    kars_pkg::t_delay   r_init_delay, r_next_delay;
    kars_pkg::t_keys    r_press, n_press;
    kars_pkg::t_keys    r_repress, n_repress;
    kars_pkg::t_keys    r_release, n_release;
    kars_pkg::t_keys    r_held, n_held;
    kars_pkg::t_addr    r_key, n_key;
    kars_pkg::t_tick    r_tick, n_tick;
    kars_pkg::t_keys    r_report, n_report;
    logic               r_out_valid, n_out_valid;
    kars_pkg::t_keys    r_out_keys, n_out_keys;

    logic               in_accept;
    logic               out_free;
    logic               last_key;
    logic               finish;
    kars_pkg::t_key_idx key_idx;
    kars_pkg::t_keys    key_mask;
    kars_pkg::t_tick    rd_deadline;
    logic               due;
    kars_pkg::t_key_dec dec;

    logic               ram_we;
    kars_pkg::t_tick    ram_wdata;
    logic               ram_re;
    kars_pkg::t_addr    ram_raddr;
    logic [kars_pkg::TICK_W-1:0] ram_rdata;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_key  = (r_key == kars_pkg::t_addr'(kars_pkg::NUM_KEYS - 1));

    // key k of the walk sits at bit k+1; positions past the mask width read as idle
    assign key_idx  = kars_pkg::t_key_idx'(r_key) + kars_pkg::t_key_idx'(1);
    assign key_mask = kars_pkg::t_keys'(1) << key_idx;

    // due once the wrapped distance to the deadline has its top bit set
    assign due = rd_deadline[kars_pkg::TICK_W-1] == 1'b0
        ? 1'b0 : 1'b1;

    kars_key_eval u_key_eval (
        .i_press   (|(r_press & key_mask)),
        .i_repress (|(r_repress & key_mask)),
        .i_release (|(r_release & key_mask)),
        .i_held    (|(r_held & key_mask)),
        .i_due     (due),
        .o_dec     (dec)
    );

    assign finish = (r_state == ST_WALK) && (dec.stop || last_key);

    // deadline store: write on a reported key, read one key ahead of the walk
    assign ram_we    = (r_state == ST_WALK) && dec.wr;
    assign ram_wdata = r_tick + kars_pkg::t_tick'(dec.use_init ? r_init_delay : r_next_delay);
    assign ram_re    = (r_state == ST_IDLE) ? (in_accept && i_opcode == kars_pkg::OP_POLL)
                                            : ((r_state == ST_WALK) && !last_key);
    assign ram_raddr = (r_state == ST_IDLE) ? '0 : r_key + kars_pkg::t_addr'(1);

    kars_ram #(
        .WIDTH (kars_pkg::TICK_W),
        .DEPTH (kars_pkg::NUM_KEYS)
    ) u_deadline_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_key),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_deadline = ram_rdata - r_tick;

    always_comb begin
        n_state     = r_state;
        n_press     = r_press;
        n_repress   = r_repress;
        n_release   = r_release;
        n_held      = r_held;
        n_key       = r_key;
        n_tick      = r_tick;
        n_report    = r_report;
        n_out_valid = r_out_valid;
        n_out_keys  = r_out_keys;

        // drain the output register
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_opcode == kars_pkg::OP_SCAN) begin
                        n_press   = r_press | i_keys_now;
                        n_repress = r_repress | (i_keys_now & r_release);
                        n_release = r_release | (r_held & ~i_keys_now);
                    end else begin
                        n_key   = '0;
                        n_tick  = i_tick_now;
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (dec.set_held) begin
                    n_held = r_held | key_mask;
                end else if (dec.clr_held) begin
                    n_held = r_held & ~key_mask;
                end
                if (finish) begin
                    n_report  = dec.report ? key_mask : '0;
                    n_press   = '0;
                    n_repress = '0;
                    n_release = '0;
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_keys  = dec.report ? key_mask : '0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_key = r_key + kars_pkg::t_addr'(1);
                end
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_keys  = r_report;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_init_delay <= kars_pkg::t_delay'(15);
            r_next_delay <= kars_pkg::t_delay'(3);
            r_press      <= '0;
            r_repress    <= '0;
            r_release    <= '0;
            r_held       <= '0;
            r_key        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_press     <= n_press;
            r_repress   <= n_repress;
            r_release   <= n_release;
            r_held      <= n_held;
            r_key       <= n_key;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kars_pkg::CFG_INITIAL_DELAY: r_init_delay <= i_cfg_data;
                    kars_pkg::CFG_NEXT_DELAY:    r_next_delay <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_tick     <= n_tick;
        r_report   <= n_report;
        r_out_keys <= n_out_keys;
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_pressed_keys = r_out_keys;

`ifndef SYNTH
    // a poll item always starts a walk, so the next cycle stalls the input
    a_poll_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_opcode == kars_pkg::OP_POLL |=> o_in_stall)
        else $error("poll accepted without starting a walk");

    // a result carries at most one key and never the unused bit 0
    a_one_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($onehot0(o_pressed_keys) && !o_pressed_keys[0]))
        else $error("result carries more than one key");

    // deadline writes happen only while walking
    a_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == ST_WALK)
        else $error("deadline write outside walk");

    // bit 0 is never a key, so it is never held
    a_no_held_bit0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held[0])
        else $error("bit 0 marked held");
`endif

endmodule

// ----- bench/kars_report_board.sv -----
// Scoreboard for the keypad auto-repeat scanner bench: predicts the key each poll reports.
// Depends on kars_pkg for widths, opcodes and register indexes.
package kars_report_board_pkg;

    import kars_pkg::*;

    localparam t_tick DUE_GAP = 8'h80;

    class press_report_board;
        t_delay first_delay;
        t_delay again_delay;
        t_keys  latch_down;
        t_keys  latch_redown;
        t_keys  latch_up;
        t_keys  held;
        t_tick  deadline [NUM_KEYS];
        t_keys  expected_presses [$];
        int     errors;
        int     polls;
        int     reports;

        function new();
            first_delay  = 7'd15;
            again_delay  = 7'd3;
            latch_down   = '0;
            latch_redown = '0;
            latch_up     = '0;
            held         = '0;
            foreach (deadline[k]) deadline[k] = '0;
            errors       = 0;
            polls        = 0;
            reports      = 0;
        endfunction

        function void set_delay(logic idx, t_delay val);
            if (idx == CFG_INITIAL_DELAY) begin
                first_delay = val;
            end else begin
                again_delay = val;
            end
        endfunction

        // Walk keys 1..11, stop at the first one latched down unless it is held and not yet due, clear the latches.
        function t_keys walk_keys(t_tick tick);
            t_keys report;
            t_keys m;
            t_tick gap;
            report = '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                m = t_keys'(2) << k;
                if ((latch_down & m) == '0) begin
                    held &= ~m;
                    continue;
                end
                if ((latch_redown & m) != '0) begin
                    report      = m;
                    held       |= m;
                    deadline[k] = tick + t_tick'(first_delay);
                end else if ((held & m) != '0) begin
                    if ((latch_up & m) != '0) held &= ~m;
                    gap = deadline[k] - tick;
                    if (gap < DUE_GAP) continue;
                    // due but released: stop here without a report
                    if ((latch_up & m) == '0) begin
                        report      = m;
                        deadline[k] = tick + t_tick'(again_delay);
                    end
                end else if ((latch_up & m) == '0) begin
                    report      = m;
                    held       |= m;
                    deadline[k] = tick + t_tick'(first_delay);
                end
                break;
            end
            latch_down   = '0;
            latch_redown = '0;
            latch_up     = '0;
            return report;
        endfunction

        function void note_item(logic op, t_keys keys, t_tick tick);
            if (op == OP_SCAN) begin
                latch_redown |= keys & latch_up;
                latch_up     |= held & ~keys;
                latch_down   |= keys;
            end else begin
                expected_presses.push_back(walk_keys(tick));
                polls++;
            end
        endfunction

        function void check_report(t_keys got, longint unsigned stamp);
            t_keys want;
            if (expected_presses.size() == 0) begin
                $display("%0d ns: pressed_keys expected none, got 0x%03h", stamp, got);
                errors++;
                return;
            end
            want = expected_presses.pop_front();
            if (want != '0) reports++;
            if (got !== want) begin
                $display("%0d ns: pressed_keys expected 0x%03h, got 0x%03h", stamp, want, got);
                errors++;
            end
        endfunction
    endclass

endpackage

// ----- bench/keypad_autorepeat_scanner_tb.sv -----
// Bench for keypad_autorepeat_scanner: directed key sequences, then random frames
// under six delay settings and three idling mixes. Depends on kars_pkg and kars_report_board_pkg.
module keypad_autorepeat_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kars_pkg::*;
    import kars_report_board_pkg::*;

    localparam int DRAIN_CYCLES = 24;  // longest poll walk plus margin
    localparam int PHASE_ITEMS  = 245;

    logic   i_clk;
    logic   i_rst_n        = 1'b0;
    logic   i_in_valid     = 1'b0;
    logic   o_in_stall;
    logic   i_opcode       = OP_SCAN;
    t_keys  i_keys_now     = '0;
    t_tick  i_tick_now     = '0;
    logic   o_out_valid;
    logic   i_out_stall    = 1'b0;
    t_keys  o_pressed_keys;
    logic   i_cfg_we       = 1'b0;
    logic   i_cfg_idx      = CFG_INITIAL_DELAY;
    t_delay i_cfg_data     = '0;

    press_report_board board;
    int send_idle = 0;   // percent of cycles the sender holds back
    int recv_idle = 0;   // percent of cycles the receiver stalls
    int items     = 0;

    keypad_autorepeat_scanner u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_keys_now    (i_keys_now),
        .i_tick_now    (i_tick_now),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pressed_keys(o_pressed_keys),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver: stall at random at the current mix.
    always @(posedge i_clk) begin
        i_out_stall <= (recv_idle != 0) && ($urandom_range(99) < recv_idle);
    end

    // Check every result taken by the receiver against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_report(o_pressed_keys, $time);
        end
    end

    // Offer one item, hold it until accepted, then note it in the scoreboard.
    // Valid stays high on return so back-to-back items never drop it in between.
    task automatic send_item(logic op, t_keys keys, t_tick tick);
        while (send_idle != 0 && $urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_keys_now <= keys;
        i_tick_now <= tick;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_item(op, keys, tick);
        items++;
    endtask

    task automatic scan(t_keys keys);
        send_item(OP_SCAN, keys, t_tick'($urandom));
    endtask

    task automatic poll(t_tick tick);
        send_item(OP_POLL, t_keys'($urandom), tick);
    endtask

    // Drop valid, wait out every pending report, then let a trailing scan settle.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (board.expected_presses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both delay registers on consecutive edges; the block is idle here.
    task automatic load_delays(t_delay first, t_delay again);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_INITIAL_DELAY;
        i_cfg_data <= first;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_NEXT_DELAY;
        i_cfg_data <= again;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_delay(CFG_INITIAL_DELAY, first);
        board.set_delay(CFG_NEXT_DELAY, again);
    endtask

    // Frames of a keypad in use: one scan of the keys down (sometimes a bounce
    // before it), then a poll a few ticks on. Keys mostly go down and up one at a time.
    // A small share of items is pure noise, and now and then the tick jumps far.
    task automatic random_frames(int n_items);
        int    stop_at;
        t_keys fingers;
        t_tick now_tick;
        stop_at  = items + n_items;
        fingers  = '0;
        now_tick = t_tick'($urandom);
        while (items < stop_at) begin
            if ($urandom_range(99) < 8) begin
                send_item(logic'($urandom_range(1)), t_keys'($urandom), t_tick'($urandom));
            end else begin
                if ($urandom_range(99) < 35) fingers ^= t_keys'(2) << $urandom_range(NUM_KEYS - 1);
                if ($urandom_range(99) < 4) fingers = '0;
                if ($urandom_range(99) < 20) begin
                    scan(fingers ^ (t_keys'(2) << $urandom_range(NUM_KEYS - 1)));
                end
                scan(fingers);
                if ($urandom_range(99) < 10) begin
                    now_tick += t_tick'($urandom_range(255));
                end else begin
                    now_tick += t_tick'($urandom_range(6));
                end
                poll(now_tick);
            end
        end
    endtask

    initial begin
        int first_set [6];
        int again_set [6];
        int send_mix  [3];
        int recv_mix  [3];
        first_set = '{0, 127, 2, 15, 5, 127};
        again_set = '{0, 127, 1, 3, 127, 0};
        send_mix  = '{37, 65, 0};
        recv_mix  = '{65, 37, 0};
        board = new();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset delays (15 and 3).
        send_idle = send_mix[0];
        recv_idle = recv_mix[0];
        poll(8'h00);            // nothing latched: empty report
        scan(12'hFFF);          // every bit, bit 0 included
        poll(8'h10);            // fresh press of key 1
        scan(12'h002);
        poll(8'h11);            // held, not yet due
        scan(12'h002);
        poll(8'h20);            // held and past its deadline: repeat
        scan(12'h002);
        scan(12'h000);          // release latched
        poll(8'h30);            // due but released: walk stops, no report
        scan(12'h002);
        poll(8'h31);            // pressed again after the drop
        scan(12'h002);
        scan(12'h000);
        scan(12'h002);          // re-press within one frame
        poll(8'h32);
        scan(12'h006);
        scan(12'h004);          // key 1 released before due, key 2 fresh
        poll(8'h33);
        scan(12'h800);          // top key, deadline wraps past 0xFF
        poll(8'hFF);
        scan(12'h800);
        poll(8'h0F);
        scan(12'h001);          // bit 0 only: no key there
        poll(8'h80);

        // Random part: two delay settings per idling mix, extremes first.
        for (int p = 0; p < 6; p++) begin
            quiesce();
            send_idle = send_mix[p / 2];
            recv_idle = recv_mix[p / 2];
            load_delays(t_delay'(first_set[p]), t_delay'(again_set[p]));
            random_frames(PHASE_ITEMS);
        end
        quiesce();

        $display("Sent %0d items, %0d of them polls; %0d keys reported.",
                 items, board.polls, board.reports);
        $display("Six delay settings (0 and 127 among them), three idling mixes.");
        if (board.errors == 0 && board.expected_presses.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timed out with %0d reports outstanding", board.expected_presses.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/kars_pkg.sv
src/kars_ram.sv
src/kars_key_eval.sv
src/keypad_autorepeat_scanner.sv
bench/kars_report_board.sv
bench/keypad_autorepeat_scanner_tb.sv
